// ----- src/html_markup_char_tokenizer_defines.svh -----
// Assertion macros used by the checker file.
`ifndef HTML_MARKUP_CHAR_TOKENIZER_DEFINES_SVH
`define HTML_MARKUP_CHAR_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HMCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HMCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ----- src/hmct_pkg.sv -----
package hmct_pkg;

  typedef enum logic [18:0] {
    ST_INITIAL    = 19'h00001,
    ST_TEXT       = 19'h00002,
    ST_TAG_START  = 19'h00004,
    ST_SLASH      = 19'h00008,
    ST_OPEN_NAME  = 19'h00010,
    ST_CLOSE_NAME = 19'h00020,
    ST_NAME_DONE  = 19'h00040,
    ST_ATTR       = 19'h00080,
    ST_ATTR_DONE  = 19'h00100,
    ST_EQUALS     = 19'h00200,
    ST_VALUE      = 19'h00400,
    ST_QVALUE     = 19'h00800,
    ST_VALUE_DONE = 19'h01000,
    ST_TAG_END    = 19'h02000,
    ST_ENT_START  = 19'h04000,
    ST_ENT        = 19'h08000,
    ST_ENT_END    = 19'h10000,
    ST_BANG       = 19'h20000,
    ST_COMMENT    = 19'h40000
  } tok_state_t;

  typedef enum logic [3:0] {
    ACT_NONE         = 4'd0,
    ACT_TEXT_START   = 4'd1,
    ACT_TEXT_FLUSH   = 4'd2,
    ACT_TAG_CHAR     = 4'd3,
    ACT_ATTR_CHAR    = 4'd4,
    ACT_VALUE_CHAR   = 4'd5,
    ACT_PAIR_DONE    = 4'd6,
    ACT_TAG_DONE     = 4'd7,
    ACT_ENTITY_CHAR  = 4'd8,
    ACT_ENTITY_DONE  = 4'd9,
    ACT_COMMENT_CHAR = 4'd10,
    ACT_COMMENT_END  = 4'd11,
    ACT_TEXT_DROPPED = 4'd12
  } action_t;

  localparam logic [4:0] CODE_INITIAL = 5'd0;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NBSP  = 8'hA0;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    tok_state_t  st;
    logic        inside_tag;
    logic        tag_is_closing;
    logic        inside_entity;
    logic        text_pending;
    logic        value_pending;
    logic [7:0]  recent0;
    logic [7:0]  recent1;
    logic [1:0]  recent_count;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    st: ST_INITIAL, inside_tag: 1'b0, tag_is_closing: 1'b0, inside_entity: 1'b0,
    text_pending: 1'b0, value_pending: 1'b0, recent0: 8'h00, recent1: 8'h00,
    recent_count: 2'd0
  };

  typedef struct packed {
    logic [4:0] parser_state;
    action_t    action;
    logic       process_char;
    logic       closing_tag;
    logic       name_restart;
    logic       value_pending;
    logic [7:0] char_echo;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_NBSP;
  endfunction

  // Dense state number from the one-hot code.
  function automatic logic [4:0] state_code(input tok_state_t s);
    logic [4:0] code;
    code = '0;
    for (int i = 0; i < 19; i++) begin
      if (s[i]) code = code | 5'(i);
    end
    return code;
  endfunction

endpackage

// ----- src/hmct_step.sv -----
module hmct_step (
  input  logic [7:0]       char_code,
  input  hmct_pkg::ctx_t   ctx,
  output hmct_pkg::ctx_t   ctx_next,
  output hmct_pkg::result_t res
);

  hmct_pkg::tok_state_t st;
  hmct_pkg::ctx_t       nx;
  hmct_pkg::action_t    act;
  logic                 proc;
  logic                 comment_gt;
  logic                 restart;
  logic                 vpend;
  logic                 dash_pair;

  assign dash_pair = ctx.recent_count == 2'd2 && ctx.recent0 == hmct_pkg::CH_DASH &&
                     ctx.recent1 == hmct_pkg::CH_DASH;

  always_comb begin
    st         = ctx.st;
    nx         = ctx;
    act        = hmct_pkg::ACT_NONE;
    proc       = 1'b1;
    comment_gt = 1'b0;
    restart    = 1'b0;
    vpend      = 1'b0;

    // Inspection: new state and whether the byte reaches the action stage.
    if (ctx.st == hmct_pkg::ST_COMMENT) begin
      if (char_code == hmct_pkg::CH_GT) comment_gt = 1'b1;
    end else if (char_code == hmct_pkg::CH_LT) begin
      nx.tag_is_closing = 1'b0;
      nx.inside_tag     = 1'b1;
      st                = hmct_pkg::ST_TAG_START;
    end else if (ctx.inside_tag) begin
      if (char_code == hmct_pkg::CH_SLASH) begin
        if (st == hmct_pkg::ST_TAG_START) begin
          nx.tag_is_closing = 1'b1;
          st                = hmct_pkg::ST_SLASH;
          proc              = 1'b0;
        end
      end else if (char_code == hmct_pkg::CH_EQ) begin
        if (st != hmct_pkg::ST_VALUE && st != hmct_pkg::ST_QVALUE) begin
          st   = hmct_pkg::ST_EQUALS;
          proc = 1'b0;
        end
      end else if (char_code == hmct_pkg::CH_QUOTE) begin
        if (st == hmct_pkg::ST_EQUALS) begin
          st   = hmct_pkg::ST_QVALUE;
          proc = 1'b0;
        end else begin
          st = hmct_pkg::ST_VALUE_DONE;
        end
      end else if (char_code == hmct_pkg::CH_GT) begin
        st            = hmct_pkg::ST_TAG_END;
        nx.inside_tag = 1'b0;
      end else if (char_code == hmct_pkg::CH_BANG) begin
        if (st == hmct_pkg::ST_TAG_START) begin
          st   = hmct_pkg::ST_BANG;
          proc = 1'b0;
        end
      end else if (hmct_pkg::is_blank(char_code)) begin
        if (st == hmct_pkg::ST_OPEN_NAME || st == hmct_pkg::ST_CLOSE_NAME) begin
          st   = hmct_pkg::ST_NAME_DONE;
          proc = 1'b0;
        end else if (st == hmct_pkg::ST_ATTR) begin
          st   = hmct_pkg::ST_ATTR_DONE;
          proc = 1'b0;
        end else if (st == hmct_pkg::ST_VALUE) begin
          st = hmct_pkg::ST_VALUE_DONE;
        end
      end else if (st == hmct_pkg::ST_BANG && char_code == hmct_pkg::CH_DASH) begin
        st   = hmct_pkg::ST_COMMENT;
        proc = 1'b0;
      end else begin
        unique case (st)
          hmct_pkg::ST_TAG_START:  st = hmct_pkg::ST_OPEN_NAME;
          hmct_pkg::ST_SLASH:      st = hmct_pkg::ST_CLOSE_NAME;
          hmct_pkg::ST_EQUALS:     st = hmct_pkg::ST_VALUE;
          hmct_pkg::ST_NAME_DONE:  st = hmct_pkg::ST_ATTR;
          hmct_pkg::ST_ATTR_DONE: begin
            restart = 1'b1;
            st      = hmct_pkg::ST_ATTR;
          end
          hmct_pkg::ST_VALUE_DONE: st = hmct_pkg::ST_ATTR;
          default: ;
        endcase
      end
    end else if (char_code == hmct_pkg::CH_AMP) begin
      st               = hmct_pkg::ST_ENT_START;
      nx.inside_entity = 1'b1;
      proc             = 1'b0;
      if (ctx.text_pending) act = hmct_pkg::ACT_TEXT_DROPPED;
      nx.text_pending  = 1'b0;
    end else if (ctx.inside_entity) begin
      if (char_code == hmct_pkg::CH_SEMI) begin
        st               = hmct_pkg::ST_ENT_END;
        nx.inside_entity = 1'b0;
      end else begin
        st = hmct_pkg::ST_ENT;
      end
    end else begin
      if (st == hmct_pkg::ST_TEXT) begin
        proc = 1'b0;
      end else if (st == hmct_pkg::ST_TAG_END || st == hmct_pkg::ST_ENT_END ||
                   st == hmct_pkg::ST_INITIAL) begin
        st = hmct_pkg::ST_TEXT;
      end
    end

    // Action stage.
    if (proc) begin
      if (comment_gt) begin
        if (dash_pair) begin
          st            = hmct_pkg::ST_INITIAL;
          nx.inside_tag = 1'b0;
          act           = hmct_pkg::ACT_COMMENT_END;
        end else begin
          st = hmct_pkg::ST_COMMENT;
        end
      end else begin
        unique case (st)
          hmct_pkg::ST_TEXT: begin
            nx.text_pending = 1'b1;
            act             = hmct_pkg::ACT_TEXT_START;
          end
          hmct_pkg::ST_OPEN_NAME, hmct_pkg::ST_CLOSE_NAME: act = hmct_pkg::ACT_TAG_CHAR;
          hmct_pkg::ST_ENT_END: act = hmct_pkg::ACT_ENTITY_DONE;
          hmct_pkg::ST_ENT:     act = hmct_pkg::ACT_ENTITY_CHAR;
          hmct_pkg::ST_ATTR:    act = hmct_pkg::ACT_ATTR_CHAR;
          hmct_pkg::ST_VALUE, hmct_pkg::ST_QVALUE: begin
            nx.value_pending = 1'b1;
            act              = hmct_pkg::ACT_VALUE_CHAR;
          end
          hmct_pkg::ST_VALUE_DONE: begin
            nx.value_pending = 1'b0;
            act              = hmct_pkg::ACT_PAIR_DONE;
          end
          hmct_pkg::ST_TAG_START: begin
            if (ctx.text_pending) begin
              nx.text_pending = 1'b0;
              act             = hmct_pkg::ACT_TEXT_FLUSH;
            end
          end
          hmct_pkg::ST_TAG_END: begin
            vpend            = ctx.value_pending;
            nx.value_pending = 1'b0;
            act              = hmct_pkg::ACT_TAG_DONE;
          end
          hmct_pkg::ST_COMMENT: begin
            if (ctx.recent_count == 2'd2) begin
              nx.recent0 = ctx.recent1;
              nx.recent1 = char_code;
            end else begin
              if (ctx.recent_count[0]) nx.recent1 = char_code;
              else nx.recent0 = char_code;
              nx.recent_count = 2'(ctx.recent_count + 2'd1);
            end
            act = hmct_pkg::ACT_COMMENT_CHAR;
          end
          default: ;
        endcase
      end
    end

    nx.st = st;
  end

  assign ctx_next          = nx;
  assign res.parser_state  = hmct_pkg::state_code(st);
  assign res.action        = act;
  assign res.process_char  = proc;
  assign res.closing_tag   = nx.tag_is_closing;
  assign res.name_restart  = restart;
  assign res.value_pending = vpend;
  assign res.char_echo     = char_code;

endmodule

// ----- src/html_markup_char_tokenizer.sv -----
// Channel   Dir  Width  Contents
// s_*       in   8      char_code
// m_*       out  24     parser_state, action, process_char, closing_tag,
//                       name_restart, value_pending, char_echo
//
// Every beat is registered on entry; its result is registered in the output register once the output can take it.
// One beat is taken per cycle while the output is not stalled; the tokenizer context updates once per beat.
// A stalled output holds its beat while one more input beat waits in the entry register.
// Synchronous reset returns the tokenizer to its initial state and empties both registers.
module html_markup_char_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [4:0] parser_state, [8:5] action, [9] process_char,
                                 // [10] closing_tag, [11] name_restart,
                                 // [12] value_pending, [20:13] char_echo, [23:21] zero
);

  logic              in_valid;
  logic [7:0]        in_char;
  logic              out_valid;
  logic [23:0]       out_data;
  logic              advance;
  hmct_pkg::ctx_t    ctx;
  hmct_pkg::ctx_t    ctx_next;
  hmct_pkg::result_t res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  hmct_step u_step (
    .char_code (in_char),
    .ctx       (ctx),
    .ctx_next  (ctx_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctx       <= hmct_pkg::CTX_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) begin
        out_valid <= 1'b1;
        ctx       <= ctx_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_char <= s_tdata;
    if (advance) begin
      out_data <= {3'b000, res.char_echo, res.value_pending, res.name_restart,
                   res.closing_tag, res.process_char, res.action, res.parser_state};
    end
  end

endmodule

// ----- src/hmct_checker.sv -----
`include "html_markup_char_tokenizer_defines.svh"

module hmct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic [4:0] out_state;
  logic [3:0] out_action;
  logic       out_proc;
  logic       out_vpend;
  logic [7:0] out_echo;
  logic       quiet_action;
  logic       comment_end_ok;

  assign out_state      = m_tdata[4:0];
  assign out_action     = m_tdata[8:5];
  assign out_proc       = m_tdata[9];
  assign out_vpend      = m_tdata[12];
  assign out_echo       = m_tdata[20:13];
  assign quiet_action   = out_action == hmct_pkg::ACT_NONE ||
                          out_action == hmct_pkg::ACT_TEXT_DROPPED;
  assign comment_end_ok = out_state == hmct_pkg::CODE_INITIAL && out_echo == hmct_pkg::CH_GT;

  `HMCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `HMCT_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
  `HMCT_ASSERT_NOW(a_idle_action, m_tvalid && !out_proc, quiet_action)
  `HMCT_ASSERT_NOW(a_comment_end, m_tvalid && out_action == hmct_pkg::ACT_COMMENT_END, comment_end_ok)
  `HMCT_ASSERT_NOW(a_value_pending, m_tvalid && out_vpend, out_action == hmct_pkg::ACT_TAG_DONE)

endmodule

bind html_markup_char_tokenizer hmct_checker u_hmct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
